FILE: design/biquad_filter_wet_dry_mix_core_assert.svh
// Assertion macros shared by the checker of the biquad wet/dry core.
// Needs a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef BIQUAD_FILTER_WET_DRY_MIX_CORE_ASSERT_SVH
`define BIQUAD_FILTER_WET_DRY_MIX_CORE_ASSERT_SVH

// general property, checked outside reset
`define BQM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// signal holds in the cycle after a condition
`define BQM_ASSERT_HOLD(lbl, cond, sig, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

FILE: design/bqm_pkg.sv
// Package for the biquad wet/dry core: sizes, register codes, state types,
// delay-line record and the round/saturate helper. No dependencies.
package bqm_pkg;

    localparam int CHANNELS       = 2;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 26;

    localparam int CHAN_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PROD_W    = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W     = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] SAT_MAX  =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_MIN  = ACC_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [COEF_BITS-1:0] DRY_RESET =
        COEF_BITS'(64'sd1 <<< COEF_FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FEED_0 = 3'd0,
        REG_FEED_1 = 3'd1,
        REG_FEED_2 = 3'd2,
        REG_BACK_1 = 3'd3,
        REG_BACK_2 = 3'd4,
        REG_WET    = 3'd5,
        REG_DRY    = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILT,
        ST_MIX,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x1;
        logic signed [SAMPLE_BITS-1:0] x2;
        logic signed [SAMPLE_BITS-1:0] y1;
        logic signed [SAMPLE_BITS-1:0] y2;
    } t_delays;

    typedef struct packed {
        logic issue;
        logic clr;
        logic sub;
    } t_mac_ctl;

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] r;
        t = acc + ACC_HALF;
        r = t >>> COEF_FRAC_BITS;
        if (r > SAT_MAX) begin
            r = SAT_MAX;
        end else if (r < SAT_MIN) begin
            r = SAT_MIN;
        end
        return SAMPLE_BITS'(r);
    endfunction

endpackage

FILE: design/bqm_delay_ram.sv
// Per-channel delay store: one synchronous memory, registered read,
// valid bits so that unwritten entries read as zero. Uses bqm_pkg.
module bqm_delay_ram (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [bqm_pkg::CHAN_AW-1:0] i_rd_addr,
    output bqm_pkg::t_delays            o_rd_data,
    input  logic                        i_wr_en,
    input  logic [bqm_pkg::CHAN_AW-1:0] i_wr_addr,
    input  bqm_pkg::t_delays            i_wr_data
);
    import bqm_pkg::*;

    t_delays              r_mem [CHANNELS];
    logic [CHANNELS-1:0]  r_valid;
    t_delays              r_rd_data;
    logic                 r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

FILE: design/bqm_mac.sv
// Shared multiply-accumulate unit: registered product, then a 64-bit
// accumulator that loads, adds or subtracts it. Uses bqm_pkg.
module bqm_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  bqm_pkg::t_mac_ctl                     i_ctl,
    input  logic signed [bqm_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic signed [bqm_pkg::COEF_BITS-1:0]   i_coef,
    output logic signed [bqm_pkg::ACC_W-1:0]       o_acc
);
    import bqm_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    t_mac_ctl                 r_ctl;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  prod_ext;

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_prod <= i_sample * i_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    assign prod_ext = ACC_W'(r_prod);

    always_comb begin
        n_acc = r_acc;
        if (r_ctl.issue) begin
            if (r_ctl.clr) begin
                n_acc = prod_ext;
            end else if (r_ctl.sub) begin
                n_acc = r_acc - prod_ext;
            end else begin
                n_acc = r_acc + prod_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

FILE: design/biquad_filter_wet_dry_mix_core.sv
// Top level of the per-channel direct form I biquad with wet/dry mix.
// Uses bqm_pkg, bqm_delay_ram and bqm_mac.
//
// Use:
//   s_axis: one item per sample; tuser = channel, tdata = signed sample.
//   m_axis: one item per input; tuser = channel, tdata = mixed sample.
//   cfg:    writes coefficient registers 0..6 (a0 a1 a2 b1 b2 wet dry),
//           index in i_cfg_index, value in i_cfg_data; always ready.
//           Write only while no item is in flight.
// Timing: one item at a time; the item passes through 7 filter steps, 2 mix
//   steps and 1 output step, in which the result register loads, and an idle
//   step to accept follows before the next item is taken. Seven products
//   share one 24x32 multiplier, one per cycle, with an accumulate stage
//   behind it; the delay memory is read at acceptance, written once.
// Reset: synchronous, active low; clears the delay store (through valid
//   bits), loads register defaults (dry gain 1.0, all others 0) and
//   empties the output register.
// Stall: the result waits in the output register; the next item may be
//   accepted and processed meanwhile, and it holds in its output step
//   until the register is taken.
module biquad_filter_wet_dry_mix_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bqm_pkg::TDATA_W-1:0]      s_axis_tdata,   // [23:0] sample_in
    input  logic                             s_axis_tuser,   // [0] chan
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bqm_pkg::TDATA_W-1:0]      m_axis_tdata,   // [23:0] sample_out
    output logic                             m_axis_tuser,   // [0] chan_out
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bqm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bqm_pkg::COEF_BITS-1:0]    i_cfg_data
);
    import bqm_pkg::*;

    localparam int STEP_W    = 3;
    localparam logic [STEP_W-1:0] FILT_LAST = 3'd6;
    localparam logic [STEP_W-1:0] MIX_LAST  = 3'd1;

    // coefficient registers
    logic signed [COEF_BITS-1:0] r_a0, r_a1, r_a2, r_b1, r_b2, r_wet, r_dry;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_chan;
    logic                r_inrange;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_z;
    logic                r_out_valid;
    logic                r_out_chan;
    logic signed [SAMPLE_BITS-1:0] r_out_data;

    logic                in_acc;
    logic                out_free;
    logic                out_load;
    logic                z_load;
    logic                wr_en;
    t_mac_ctl            mac_ctl;
    logic signed [SAMPLE_BITS-1:0] mac_sample;
    logic signed [COEF_BITS-1:0]   mac_coef;
    logic signed [ACC_W-1:0]       acc;
    t_delays             rd_data;
    t_delays             wr_data;
    logic [CHAN_AW-1:0]  rd_addr;
    logic [CHAN_AW-1:0]  wr_addr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a0  <= '0;
            r_a1  <= '0;
            r_a2  <= '0;
            r_b1  <= '0;
            r_b2  <= '0;
            r_wet <= '0;
            r_dry <= DRY_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_FEED_0: r_a0  <= i_cfg_data;
                REG_FEED_1: r_a1  <= i_cfg_data;
                REG_FEED_2: r_a2  <= i_cfg_data;
                REG_BACK_1: r_b1  <= i_cfg_data;
                REG_BACK_2: r_b2  <= i_cfg_data;
                REG_WET:    r_wet <= i_cfg_data;
                REG_DRY:    r_dry <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign rd_addr  = CHAN_AW'(s_axis_tuser);
    assign wr_addr  = CHAN_AW'(r_chan);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc) n_state = ST_FILT;
            ST_FILT: if (r_step == FILT_LAST) n_state = ST_MIX;
            ST_MIX:  if (r_step == MIX_LAST) n_state = ST_OUT;
            ST_OUT:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        n_step = (n_state != r_state) ? '0 : r_step + 3'd1;
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        mac_ctl       = '0;
        mac_sample    = r_x;
        mac_coef      = r_a0;
        z_load        = 1'b0;
        wr_en         = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_FILT: begin
                priority case (r_step)
                    3'd0: begin
                        mac_ctl = '{issue: 1'b1, clr: 1'b1, sub: 1'b0};
                    end
                    3'd1: begin
                        mac_ctl    = '{issue: 1'b1, clr: 1'b0, sub: 1'b0};
                        mac_sample = rd_data.x1;
                        mac_coef   = r_a1;
                    end
                    3'd2: begin
                        mac_ctl    = '{issue: 1'b1, clr: 1'b0, sub: 1'b0};
                        mac_sample = rd_data.x2;
                        mac_coef   = r_a2;
                    end
                    3'd3: begin
                        mac_ctl    = '{issue: 1'b1, clr: 1'b0, sub: 1'b1};
                        mac_sample = rd_data.y1;
                        mac_coef   = r_b1;
                    end
                    3'd4: begin
                        mac_ctl    = '{issue: 1'b1, clr: 1'b0, sub: 1'b1};
                        mac_sample = rd_data.y2;
                        mac_coef   = r_b2;
                    end
                    3'd5: begin
                        // dry path starts while the filter sum settles
                        mac_ctl  = '{issue: 1'b1, clr: 1'b1, sub: 1'b0};
                        mac_coef = r_dry;
                    end
                    default: z_load = 1'b1;
                endcase
            end
            ST_MIX: begin
                if (r_step == '0) begin
                    mac_ctl    = '{issue: 1'b1, clr: 1'b0, sub: 1'b0};
                    mac_sample = r_z;
                    mac_coef   = r_wet;
                    wr_en      = r_inrange;
                end
            end
            ST_OUT: out_load = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x       <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_chan    <= s_axis_tuser;
            r_inrange <= 32'(s_axis_tuser) < 32'(CHANNELS);
        end
        if (z_load) begin
            r_z <= round_sat(acc);
        end
        if (out_load) begin
            r_out_chan <= r_chan;
            r_out_data <= r_inrange ? round_sat(acc) : '0;
        end
    end

    assign wr_data = '{x1: r_x, x2: rd_data.x1, y1: r_z, y2: rd_data.y1};

    bqm_delay_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    bqm_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_sample (mac_sample),
        .i_coef   (mac_coef),
        .o_acc    (acc)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_chan;
    assign m_axis_tdata  = TDATA_W'(unsigned'(r_out_data));

endmodule

FILE: design/bqm_checker.sv
// Port-level checker for the biquad wet/dry core, bound to the top level.
// Uses bqm_pkg and the assertion macros header.
`include "biquad_filter_wet_dry_mix_core_assert.svh"

module bqm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [bqm_pkg::TDATA_W-1:0]   m_axis_tdata,
    input logic                          m_axis_tuser
);
    import bqm_pkg::*;

    logic               s_acc;
    logic               m_stall;
    logic [TDATA_W+1:0] m_bus;

    assign s_acc   = s_axis_tvalid && s_axis_tready;
    assign m_stall = m_axis_tvalid && !m_axis_tready;
    assign m_bus   = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};

    `BQM_ASSERT(a_busy_after_accept, (s_acc |=> !s_axis_tready), "input taken while busy")
    `BQM_ASSERT(a_busy_through_filter, (s_acc |-> ##6 !s_axis_tready), "item finished too early")
    `BQM_ASSERT(a_result_when_idle, ($rose(m_axis_tvalid) |-> s_axis_tready), "result while busy")
    `BQM_ASSERT_HOLD(a_result_held, m_stall, m_bus, "stalled item changed")

endmodule

bind biquad_filter_wet_dry_mix_core bqm_checker u_bqm_checker (.*);
